// ----- hdl/frse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frse_pkg;

    // field widths fixed by the stream format
    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 4;
    localparam int POINTS_W    = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 40;

    localparam int DEFAULT_MAX_POINTS    = 16;
    localparam int DEFAULT_FRACTION_BITS = 28;
    localparam int MIN_POINTS            = 3;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADVECTION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POINTS    = 2'd2;

    localparam logic signed [DATA_W-1:0] DIFFUSION_RESET = 32'sd89478485;
    localparam logic signed [DATA_W-1:0] ADVECTION_RESET = -32'sd40265318;
    localparam logic [POINTS_W-1:0]      POINTS_RESET    = 5'd11;

    // multiplier: 32-bit operand times one 20-bit slice of a 36-bit operand
    localparam int SPLIT_W = 16;
    localparam int OPB_W   = 36;
    localparam int PART_W  = OPB_W - SPLIT_W;
    localparam int PROD_W  = DATA_W + PART_W;
    localparam int ACC_W   = 54;

    // microprogram
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
    localparam logic [PC_W-1:0] PC_FILL  = 5'd1;
    localparam logic [PC_W-1:0] PC_POINT = 5'd6;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT,
        SEQ_LOOP,
        SEQ_HOME
    } seq_op_t;

    typedef enum logic [1:0] {
        MA_C,
        MA_KD,
        MA_SQ,
        MA_KA
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_C,
        MB_LAP,
        MB_DIF,
        MB_G
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOW,
        ACC_HIGH
    } acc_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SQ,
        WR_D,
        WR_G,
        WR_A
    } wr_dest_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_LEFT,
        EM_POINT,
        EM_RIGHT
    } emit_t;

    typedef struct packed {
        seq_op_t          seq;
        logic [PC_W-1:0]  target;
        logic             rd;
        logic             shift;
        logic             clr_flag;
        logic             mul_en;
        logic             mul_hi;
        mul_a_t           mul_a;
        mul_b_t           mul_b;
        acc_op_t          acc;
        wr_dest_t         wr;
        emit_t            emit;
    } uword_t;

    typedef struct packed {
        logic     start;
        logic     load;
        logic     rd;
        logic     shift;
        logic     clr_flag;
        logic     mul_en;
        logic     mul_hi;
        mul_a_t   mul_a;
        mul_b_t   mul_b;
        acc_op_t  acc;
        wr_dest_t wr;
        emit_t    emit;
    } dp_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/frse_ucode_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frse_ucode_rom (
    input  wire logic [frse_pkg::PC_W-1:0] pc,
    output frse_pkg::uword_t               word
);
    import frse_pkg::*;

    localparam uword_t NOP_WORD = '{
        seq:      SEQ_NEXT,
        target:   PC_WAIT,
        rd:       1'b0,
        shift:    1'b0,
        clr_flag: 1'b0,
        mul_en:   1'b0,
        mul_hi:   1'b0,
        mul_a:    MA_C,
        mul_b:    MB_C,
        acc:      ACC_NONE,
        wr:       WR_NONE,
        emit:     EM_NONE
    };

    // per point: sq = c*c, d = kd*lap, g = sq*dif, a = ka*g, each as a low
    // slice product then a high slice product folded into the accumulator
    always_comb begin
        word = NOP_WORD;
        case (pc)
            PC_WAIT: begin
                word.seq = SEQ_WAIT;
            end
            PC_FILL: begin
                word.rd = 1'b1;
            end
            PC_FILL + 5'd1: begin
                word.rd    = 1'b1;
                word.shift = 1'b1;
            end
            PC_FILL + 5'd2: begin
                word.rd    = 1'b1;
                word.shift = 1'b1;
            end
            PC_FILL + 5'd3: begin
                word.shift = 1'b1;
            end
            PC_FILL + 5'd4: begin
                word.emit = EM_LEFT;
            end
            PC_POINT: begin
                word.rd       = 1'b1;
                word.clr_flag = 1'b1;
                word.mul_en   = 1'b1;
                word.mul_a    = MA_C;
                word.mul_b    = MB_C;
            end
            PC_POINT + 5'd1: begin
                word.mul_en = 1'b1;
                word.mul_hi = 1'b1;
                word.mul_a  = MA_C;
                word.mul_b  = MB_C;
                word.acc    = ACC_LOW;
            end
            PC_POINT + 5'd2: begin
                word.mul_en = 1'b1;
                word.mul_a  = MA_KD;
                word.mul_b  = MB_LAP;
                word.acc    = ACC_HIGH;
            end
            PC_POINT + 5'd3: begin
                word.mul_en = 1'b1;
                word.mul_hi = 1'b1;
                word.mul_a  = MA_KD;
                word.mul_b  = MB_LAP;
                word.acc    = ACC_LOW;
                word.wr     = WR_SQ;
            end
            PC_POINT + 5'd4: begin
                word.acc = ACC_HIGH;
            end
            PC_POINT + 5'd5: begin
                word.wr     = WR_D;
                word.mul_en = 1'b1;
                word.mul_a  = MA_SQ;
                word.mul_b  = MB_DIF;
            end
            PC_POINT + 5'd6: begin
                word.mul_en = 1'b1;
                word.mul_hi = 1'b1;
                word.mul_a  = MA_SQ;
                word.mul_b  = MB_DIF;
                word.acc    = ACC_LOW;
            end
            PC_POINT + 5'd7: begin
                word.acc = ACC_HIGH;
            end
            PC_POINT + 5'd8: begin
                word.wr = WR_G;
            end
            PC_POINT + 5'd9: begin
                word.mul_en = 1'b1;
                word.mul_a  = MA_KA;
                word.mul_b  = MB_G;
            end
            PC_POINT + 5'd10: begin
                word.mul_en = 1'b1;
                word.mul_hi = 1'b1;
                word.mul_a  = MA_KA;
                word.mul_b  = MB_G;
                word.acc    = ACC_LOW;
            end
            PC_POINT + 5'd11: begin
                word.acc = ACC_HIGH;
            end
            PC_POINT + 5'd12: begin
                word.wr = WR_A;
            end
            PC_POINT + 5'd13: begin
                word.emit   = EM_POINT;
                word.shift  = 1'b1;
                word.seq    = SEQ_LOOP;
                word.target = PC_POINT;
            end
            PC_POINT + 5'd14: begin
                word.emit   = EM_RIGHT;
                word.seq    = SEQ_HOME;
                word.target = PC_WAIT;
            end
            default: begin
                word.seq    = SEQ_HOME;
                word.target = PC_WAIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/frse_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frse_sequencer #(
    parameter int MAX_POINTS = frse_pkg::DEFAULT_MAX_POINTS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_action,
    output logic                                     s_tready,
    input  wire logic [frse_pkg::POINTS_W-1:0]       points_in_use,
    input  wire logic                                out_free,
    output frse_pkg::dp_ctrl_t                       ctrl,
    output logic [$clog2(MAX_POINTS+1)-1:0]          row_pos,
    output logic [$clog2(MAX_POINTS+1)-1:0]          rd_addr
);
    import frse_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > POINTS_W ? CNT_W : POINTS_W) + 1;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] pt_reg, pt_next;
    logic [CNT_W:0]   rd_ptr_reg, rd_ptr_next;

    uword_t           word;
    logic             s_fire;
    logic             adv;
    logic             more;
    logic [CMP_W-1:0] pin_ext;
    logic [CMP_W-1:0] n_eff;

    frse_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    always_comb begin
        pin_ext = CMP_W'(points_in_use);
        if (pin_ext < CMP_W'(MIN_POINTS)) begin
            n_eff = CMP_W'(MIN_POINTS);
        end else if (pin_ext > CMP_W'(MAX_POINTS)) begin
            n_eff = CMP_W'(MAX_POINTS);
        end else begin
            n_eff = pin_ext;
        end
    end

    assign s_tready = (word.seq == SEQ_WAIT);
    assign s_fire   = s_tvalid && s_tready;
    assign more     = (CMP_W'(pt_reg) + CMP_W'(2)) < n_eff;

    // an emit step holds until the output register can take the transaction
    always_comb begin
        if (word.seq == SEQ_WAIT) begin
            adv = s_fire && s_action;
        end else begin
            adv = (word.emit == EM_NONE) || out_free;
        end
    end

    always_comb begin
        pc_next     = pc_reg;
        pt_next     = pt_reg;
        rd_ptr_next = rd_ptr_reg;
        if (adv) begin
            case (word.seq)
                SEQ_WAIT: begin
                    pc_next     = pc_reg + PC_W'(1);
                    pt_next     = CNT_W'(1);
                    rd_ptr_next = '0;
                end
                SEQ_LOOP: begin
                    if (more) begin
                        pc_next = word.target;
                        pt_next = pt_reg + CNT_W'(1);
                    end else begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
                SEQ_HOME: begin
                    pc_next = word.target;
                end
                default: begin
                    pc_next = pc_reg + PC_W'(1);
                end
            endcase
            if (word.rd) begin
                rd_ptr_next = rd_ptr_reg + (CNT_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= PC_WAIT;
            pt_reg     <= CNT_W'(1);
            rd_ptr_reg <= '0;
        end else begin
            pc_reg     <= pc_next;
            pt_reg     <= pt_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_comb begin
        case (word.emit)
            EM_POINT: row_pos = pt_reg;
            EM_RIGHT: row_pos = CNT_W'(n_eff - CMP_W'(1));
            default:  row_pos = '0;
        endcase
    end

    assign rd_addr = rd_ptr_reg[CNT_W-1:0];

    always_comb begin
        ctrl.start    = s_fire && s_action;
        ctrl.load     = s_fire && !s_action;
        ctrl.rd       = adv && word.rd;
        ctrl.shift    = adv && word.shift;
        ctrl.clr_flag = adv && word.clr_flag;
        ctrl.mul_en   = adv && word.mul_en;
        ctrl.mul_hi   = word.mul_hi;
        ctrl.mul_a    = word.mul_a;
        ctrl.mul_b    = word.mul_b;
        ctrl.acc      = adv ? word.acc : ACC_NONE;
        ctrl.wr       = adv ? word.wr : WR_NONE;
        ctrl.emit     = adv ? word.emit : EM_NONE;
    end

    a_point_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        (word.emit == EM_POINT) |->
            (pt_reg != '0) && (CMP_W'(pt_reg) + CMP_W'(2) <= CMP_W'(MAX_POINTS)))
        else $error("interior point counter out of range");

    a_rd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (CMP_W'(rd_ptr_reg) <= CMP_W'(MAX_POINTS + 1)))
        else $error("row read pointer ran past the row");

    a_step_starts_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_action) |=> (pc_reg == PC_FILL))
        else $error("step transaction did not start the row fetch");

endmodule

`default_nettype wire

// ----- hdl/frse_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frse_datapath #(
    parameter int MAX_POINTS    = frse_pkg::DEFAULT_MAX_POINTS,
    parameter int FRACTION_BITS = frse_pkg::DEFAULT_FRACTION_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire frse_pkg::dp_ctrl_t                   ctrl,
    input  wire logic [$clog2(MAX_POINTS+1)-1:0]      row_pos,
    input  wire logic [$clog2(MAX_POINTS+1)-1:0]      rd_addr,
    input  wire logic [frse_pkg::INDEX_W-1:0]         point_index,
    input  wire logic signed [frse_pkg::DATA_W-1:0]   load_value,
    input  wire logic signed [frse_pkg::DATA_W-1:0]   left_boundary,
    input  wire logic signed [frse_pkg::DATA_W-1:0]   right_boundary,
    input  wire logic signed [frse_pkg::DATA_W-1:0]   diffusion_gain,
    input  wire logic signed [frse_pkg::DATA_W-1:0]   advection_gain,
    output logic                                      out_free,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [frse_pkg::INDEX_W-1:0]              out_index,
    output logic signed [frse_pkg::DATA_W-1:0]        out_value,
    output logic                                      saturated,
    output logic                                      last_point
);
    import frse_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int PIDX_W = (IDX_W > INDEX_W ? IDX_W : INDEX_W) + 1;
    localparam int SHIFT  = FRACTION_BITS - SPLIT_W;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRACTION_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [DATA_W-1:0] row_mem [MAX_POINTS];

    logic signed [DATA_W-1:0] rd_q_reg;
    logic signed [DATA_W-1:0] p_reg, c_reg, n_reg;
    logic signed [DATA_W-1:0] sq_reg, d_reg, g_reg, a_reg;
    logic signed [DATA_W-1:0] left_reg, right_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     flag_reg;

    logic                     m_valid_reg;
    logic [INDEX_W-1:0]       m_index_reg;
    logic signed [DATA_W-1:0] m_value_reg;
    logic                     m_sat_reg;
    logic                     m_last_reg;

    logic signed [DATA_W-1:0] op_a;
    logic signed [OPB_W-1:0]  op_b, lap, dif;
    logic signed [PART_W-1:0] op_part;
    logic signed [ACC_W-1:0]  acc_shifted, sum;
    logic [DATA_W:0]          wr_sat, pt_sat;
    logic signed [DATA_W-1:0] emit_val;
    logic                     emit_sat;
    logic                     emit_last;
    logic [PIDX_W-1:0]        pidx_ext;
    logic                     load_ok;

    function automatic logic [DATA_W:0] sat_word(input logic signed [ACC_W-1:0] x);
        logic [DATA_W:0] r;
        if (x > SAT_HI) begin
            r = {1'b1, SAT_HI[DATA_W-1:0]};
        end else if (x < SAT_LO) begin
            r = {1'b1, SAT_LO[DATA_W-1:0]};
        end else begin
            r = {1'b0, x[DATA_W-1:0]};
        end
        return r;
    endfunction

    // stencil terms, exact in 36 bits
    assign lap = OPB_W'(p_reg) - (OPB_W'(c_reg) <<< 1) + OPB_W'(n_reg);
    assign dif = OPB_W'(n_reg) - OPB_W'(p_reg);

    always_comb begin
        case (ctrl.mul_a)
            MA_C:    op_a = c_reg;
            MA_KD:   op_a = diffusion_gain;
            MA_SQ:   op_a = sq_reg;
            MA_KA:   op_a = advection_gain;
            default: op_a = c_reg;
        endcase
        case (ctrl.mul_b)
            MB_C:    op_b = OPB_W'(c_reg);
            MB_LAP:  op_b = lap;
            MB_DIF:  op_b = dif;
            MB_G:    op_b = OPB_W'(g_reg);
            default: op_b = OPB_W'(c_reg);
        endcase
    end

    // low slice is unsigned, high slice carries the sign
    assign op_part = ctrl.mul_hi ? op_b[OPB_W-1:SPLIT_W]
                                 : {{(PART_W - SPLIT_W){1'b0}}, op_b[SPLIT_W-1:0]};

    assign acc_shifted = acc_reg >>> SHIFT;
    assign wr_sat      = sat_word(acc_shifted);
    assign sum         = ACC_W'(c_reg) + ACC_W'(d_reg) + ACC_W'(a_reg);
    assign pt_sat      = sat_word(sum);

    always_comb begin
        emit_val  = left_reg;
        emit_sat  = 1'b0;
        emit_last = 1'b0;
        case (ctrl.emit)
            EM_POINT: begin
                emit_val = pt_sat[DATA_W-1:0];
                emit_sat = flag_reg || pt_sat[DATA_W];
            end
            EM_RIGHT: begin
                emit_val  = right_reg;
                emit_last = 1'b1;
            end
            default: begin
                emit_val = left_reg;
            end
        endcase
    end

    assign pidx_ext = PIDX_W'(point_index);
    assign load_ok  = pidx_ext < PIDX_W'(MAX_POINTS);

    // row store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.load && load_ok) begin
            row_mem[pidx_ext[IDX_W-1:0]] <= load_value;
        end else if (ctrl.emit != EM_NONE) begin
            row_mem[row_pos[IDX_W-1:0]] <= emit_val;
        end
        if (ctrl.rd) begin
            rd_q_reg <= row_mem[rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            left_reg  <= left_boundary;
            right_reg <= right_boundary;
        end
        if (ctrl.shift) begin
            p_reg <= c_reg;
            c_reg <= n_reg;
            n_reg <= rd_q_reg;
        end
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_part;
        end
        case (ctrl.acc)
            ACC_LOW:  acc_reg <= ACC_W'(prod_reg) + ROUND_HALF;
            ACC_HIGH: acc_reg <= ACC_W'(prod_reg) + (acc_reg >>> SPLIT_W);
            default:  acc_reg <= acc_reg;
        endcase
        case (ctrl.wr)
            WR_SQ:   sq_reg <= wr_sat[DATA_W-1:0];
            WR_D:    d_reg  <= wr_sat[DATA_W-1:0];
            WR_G:    g_reg  <= wr_sat[DATA_W-1:0];
            WR_A:    a_reg  <= wr_sat[DATA_W-1:0];
            default: ;
        endcase
        if (ctrl.clr_flag) begin
            flag_reg <= 1'b0;
        end else if (ctrl.wr != WR_NONE) begin
            flag_reg <= flag_reg || wr_sat[DATA_W];
        end
        if (ctrl.emit != EM_NONE) begin
            m_index_reg <= INDEX_W'(row_pos);
            m_value_reg <= emit_val;
            m_sat_reg   <= emit_sat;
            m_last_reg  <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.emit != EM_NONE) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign out_free   = !m_valid_reg || m_tready;
    assign m_tvalid   = m_valid_reg;
    assign out_index  = m_index_reg;
    assign out_value  = m_value_reg;
    assign saturated  = m_sat_reg;
    assign last_point = m_last_reg;

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.emit != EM_NONE) |-> out_free)
        else $error("point emitted over an untaken transaction");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.emit != EM_NONE) |=> m_tvalid)
        else $error("emitted point not presented");

    a_right_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.emit == EM_RIGHT) |=> (last_point && !saturated))
        else $error("right boundary not marked as end of row");

endmodule

`default_nettype wire

// ----- hdl/ftcs_row_stencil_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Explicit finite-difference row engine for u_t = A*u_xx + B*u^2*u_x in signed
// Q4.28 (FRACTION_BITS fraction bits). A load transaction (tuser 0) writes one
// point of the row store. A step transaction (tuser 1) brings the new left and
// right boundary values; the engine then walks the interior points, computing
// c + kd*(p-2c+n) + ka*c*c*(n-p) with round-half-up products and saturation,
// updates the row in place and streams out every point of the new row, index 0
// first, tlast on the final point and tuser set where any term of that point
// clipped. The row length n is points_in_use clamped to 3..MAX_POINTS; each
// interior point runs fourteen microcode steps through the single 32x20
// multiplier and its accumulator.
// Every point read must have been loaded at least once beforehand.
module ftcs_row_stencil_engine #(
    parameter int MAX_POINTS    = frse_pkg::DEFAULT_MAX_POINTS,
    parameter int FRACTION_BITS = frse_pkg::DEFAULT_FRACTION_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // point_index, load_value, left_boundary, right_boundary, zero pad
    input  wire logic [frse_pkg::S_TDATA_W-1:0]        s_tdata,
    // action
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // out_index, out_value, zero pad
    output logic [frse_pkg::M_TDATA_W-1:0]             m_tdata,
    // saturated
    output logic                                       m_tuser,
    output logic                                       m_tlast,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [frse_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [frse_pkg::DATA_W-1:0]           cfg_data
);
    import frse_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic signed [DATA_W-1:0] kd_reg;
    logic signed [DATA_W-1:0] ka_reg;
    logic [POINTS_W-1:0]      points_reg;

    dp_ctrl_t                 ctrl;
    logic                     out_free;
    logic [CNT_W-1:0]         row_pos;
    logic [CNT_W-1:0]         rd_addr;
    logic [INDEX_W-1:0]       out_index;
    logic signed [DATA_W-1:0] out_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kd_reg     <= DIFFUSION_RESET;
            ka_reg     <= ADVECTION_RESET;
            points_reg <= POINTS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DIFFUSION: kd_reg     <= cfg_data;
                REG_ADVECTION: ka_reg     <= cfg_data;
                REG_POINTS:    points_reg <= cfg_data[POINTS_W-1:0];
                default:       ;
            endcase
        end
    end

    frse_sequencer #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_action      (s_tuser),
        .s_tready      (s_tready),
        .points_in_use (points_reg),
        .out_free      (out_free),
        .ctrl          (ctrl),
        .row_pos       (row_pos),
        .rd_addr       (rd_addr)
    );

    frse_datapath #(
        .MAX_POINTS    (MAX_POINTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .row_pos        (row_pos),
        .rd_addr        (rd_addr),
        .point_index    (s_tdata[INDEX_W-1:0]),
        .load_value     (s_tdata[INDEX_W+DATA_W-1:INDEX_W]),
        .left_boundary  (s_tdata[INDEX_W+2*DATA_W-1:INDEX_W+DATA_W]),
        .right_boundary (s_tdata[INDEX_W+3*DATA_W-1:INDEX_W+2*DATA_W]),
        .diffusion_gain (kd_reg),
        .advection_gain (ka_reg),
        .out_free       (out_free),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_index      (out_index),
        .out_value      (out_value),
        .saturated      (m_tuser),
        .last_point     (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - INDEX_W - DATA_W){1'b0}}, out_value, out_index};

endmodule

`default_nettype wire
